[src/slec_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slec_pkg: shared types and constants of the string literal escape counter
// Byte class record, parse phases, status codes and the widths of the
// line counts, running totals and the byte queue.
// ----------------------------------------------------------------------------
package slec_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int TOTAL_BITS    = 32;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;

    typedef struct packed {
        logic is_quote;
        logic is_bslash;
        logic is_x;
        logic is_hex;
        logic last;
    } byte_class_t;

    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_QUOTE = 2'd1,
        ST_ESC   = 2'd2,
        ST_HEX   = 2'd3
    } status_t;

endpackage
`default_nettype wire

[src/string_literal_escape_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// string_literal_escape_counter: quoted literal length and decode counter
// Input channel: one raw byte of a quoted literal per transfer (char_byte),
// line_end set on the last byte of the line. Output channel: one transfer
// per line with the raw length, the decoded length (zero unless status is
// ok), the status and the wrapping running totals of both lengths.
// Throughput is one byte per cycle unless out_stall holds a line result: the
// parser updates its phase and counts per byte, and the classifier and parser
// are decoupled by a four-entry queue so either side can stall independently.
// out_valid rises once the last byte of a line has passed the classifier
// register and the queue and the parser has registered the line result.
// A line result waits in the output register while out_stall is high; bytes
// keep flowing into the parser until it reaches the next line's last byte,
// then back-pressure reaches in_stall through the queue.
// Reset clears the parse state, the line counts, the totals and the queue;
// the block accepts bytes as soon as reset is released.
// ----------------------------------------------------------------------------
module string_literal_escape_counter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     char_byte,
    input  wire logic                           line_end,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [slec_pkg::COUNT_BITS-1:0]     code_count,
    output logic [slec_pkg::COUNT_BITS-1:0]     memory_count,
    output logic [1:0]                          status,
    output logic [slec_pkg::TOTAL_BITS-1:0]     code_total,
    output logic [slec_pkg::TOTAL_BITS-1:0]     memory_total
);

    logic                  cls_valid;
    slec_pkg::byte_class_t cls;
    logic                  fifo_full;
    logic                  fifo_not_empty;
    slec_pkg::byte_class_t fifo_head;
    logic                  fifo_pop;
    logic                  fifo_push;

    assign fifo_push = cls_valid && !fifo_full;

    slec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_byte (char_byte),
        .line_end  (line_end),
        .cls_valid (cls_valid),
        .cls       (cls),
        .cls_full  (fifo_full)
    );

    slec_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (cls),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .head      (fifo_head)
    );

    slec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (fifo_not_empty),
        .item         (fifo_head),
        .item_pop     (fifo_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_count   (code_count),
        .memory_count (memory_count),
        .status       (status),
        .code_total   (code_total),
        .memory_total (memory_total)
    );

endmodule
`default_nettype wire

[src/slec_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slec_front: byte classifier
// Accepts raw bytes, tags quote, backslash, 'x' and hex digits and holds the
// tagged byte in a register until the queue takes it.
// ----------------------------------------------------------------------------
module slec_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            char_byte,
    input  wire logic                  line_end,
    output logic                       cls_valid,
    output slec_pkg::byte_class_t      cls,
    input  wire logic                  cls_full
);

    logic                  valid_reg;
    logic                  valid_next;
    slec_pkg::byte_class_t cls_reg;
    slec_pkg::byte_class_t cls_next;
    logic                  take;

    function automatic logic is_hex_digit(input logic [7:0] c);
        return ((c >= slec_pkg::CHAR_ZERO)  && (c <= slec_pkg::CHAR_NINE))  ||
               ((c >= slec_pkg::CHAR_LOW_A) && (c <= slec_pkg::CHAR_LOW_F)) ||
               ((c >= slec_pkg::CHAR_UP_A)  && (c <= slec_pkg::CHAR_UP_F));
    endfunction

    assign in_stall  = valid_reg && cls_full;
    assign take      = in_valid && !in_stall;
    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

    always_comb
    begin
        cls_next.is_quote  = (char_byte == slec_pkg::CHAR_QUOTE);
        cls_next.is_bslash = (char_byte == slec_pkg::CHAR_BSLASH);
        cls_next.is_x      = (char_byte == slec_pkg::CHAR_X);
        cls_next.is_hex    = is_hex_digit(char_byte);
        cls_next.last      = line_end;
        if (take)
            valid_next = 1'b1;
        else if (!cls_full)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cls_reg <= cls_next;
    end

endmodule
`default_nettype wire

[src/slec_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slec_fifo: byte class queue
// Short first-in first-out queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module slec_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire slec_pkg::byte_class_t push_data,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       not_empty,
    output slec_pkg::byte_class_t      head
);

    slec_pkg::byte_class_t                 mem [slec_pkg::FIFO_DEPTH];
    logic [slec_pkg::FIFO_PTR_BITS-1:0]    wr_ptr_reg;
    logic [slec_pkg::FIFO_PTR_BITS-1:0]    rd_ptr_reg;
    logic [slec_pkg::FIFO_CNT_BITS-1:0]    cnt_reg;
    logic [slec_pkg::FIFO_CNT_BITS-1:0]    cnt_next;

    assign full      = (cnt_reg == slec_pkg::FIFO_CNT_BITS'(slec_pkg::FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= slec_pkg::FIFO_CNT_BITS'(slec_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

[src/slec_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slec_back: escape parser and result stage
// Steps the parse phase one classified byte per cycle unless out_stall holds
// a result; keeps line counts, running totals and each result until taken.
// ----------------------------------------------------------------------------
module slec_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    input  wire slec_pkg::byte_class_t              item,
    output logic                                    item_pop,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [slec_pkg::COUNT_BITS-1:0]         code_count,
    output logic [slec_pkg::COUNT_BITS-1:0]         memory_count,
    output logic [1:0]                              status,
    output logic [slec_pkg::TOTAL_BITS-1:0]         code_total,
    output logic [slec_pkg::TOTAL_BITS-1:0]         memory_total
);

    slec_pkg::phase_t                    phase_reg, phase_next;
    slec_pkg::status_t                   err_reg, err_next;
    logic [slec_pkg::COUNT_BITS-1:0]     len_reg, len_next;
    logic [slec_pkg::COUNT_BITS-1:0]     dec_reg, dec_next;
    logic [slec_pkg::TOTAL_BITS-1:0]     raw_sum_reg, raw_sum_next;
    logic [slec_pkg::TOTAL_BITS-1:0]     dec_sum_reg, dec_sum_next;
    logic                                out_valid_reg, out_valid_next;
    logic [slec_pkg::COUNT_BITS-1:0]     code_count_reg;
    logic [slec_pkg::COUNT_BITS-1:0]     memory_count_reg;
    slec_pkg::status_t                   status_reg;
    logic [slec_pkg::COUNT_BITS-1:0]     len_inc;
    logic [slec_pkg::COUNT_BITS-1:0]     dec_inc;
    logic [slec_pkg::COUNT_BITS-1:0]     mem_cnt;
    logic                                line_done;

    // a line result may only move forward if the result register is free
    assign item_pop  = item_valid && !(item.last && out_valid_reg && out_stall);
    assign line_done = item_pop && item.last;

    assign len_inc = (len_reg == '1) ? len_reg : len_reg + 1'b1;
    assign dec_inc = (dec_reg == '1) ? dec_reg : dec_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        dec_next   = dec_reg;
        len_next   = len_inc;
        if (phase_reg == slec_pkg::PH_OPEN)
        begin
            if (!item.is_quote || item.last)
                err_next = slec_pkg::ST_QUOTE;
            phase_next = slec_pkg::PH_BODY;
        end
        else if (item.last)
        begin
            if (!item.is_quote)
                err_next = slec_pkg::ST_QUOTE;
            else if (err_reg == slec_pkg::ST_OK)
            begin
                if (phase_reg == slec_pkg::PH_ESC)
                    err_next = slec_pkg::ST_QUOTE;
                else if (phase_reg == slec_pkg::PH_HEX1 || phase_reg == slec_pkg::PH_HEX2)
                    err_next = slec_pkg::ST_HEX;
            end
        end
        else if (err_reg == slec_pkg::ST_OK)
        begin
            unique case (phase_reg)
                slec_pkg::PH_ESC:
                begin
                    if (item.is_bslash || item.is_quote)
                    begin
                        dec_next   = dec_inc;
                        phase_next = slec_pkg::PH_BODY;
                    end
                    else if (item.is_x)
                        phase_next = slec_pkg::PH_HEX1;
                    else
                        err_next = slec_pkg::ST_ESC;
                end
                slec_pkg::PH_HEX1:
                begin
                    if (item.is_hex)
                        phase_next = slec_pkg::PH_HEX2;
                    else
                        err_next = slec_pkg::ST_HEX;
                end
                slec_pkg::PH_HEX2:
                begin
                    if (item.is_hex)
                    begin
                        dec_next   = dec_inc;
                        phase_next = slec_pkg::PH_BODY;
                    end
                    else
                        err_next = slec_pkg::ST_HEX;
                end
                default:
                begin
                    if (item.is_bslash)
                        phase_next = slec_pkg::PH_ESC;
                    else
                        dec_next = dec_inc;
                end
            endcase
        end

        mem_cnt      = (err_next == slec_pkg::ST_OK) ? dec_next : '0;
        raw_sum_next = raw_sum_reg + slec_pkg::TOTAL_BITS'(len_next);
        dec_sum_next = dec_sum_reg + slec_pkg::TOTAL_BITS'(mem_cnt);

        if (line_done)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= slec_pkg::PH_OPEN;
            err_reg       <= slec_pkg::ST_OK;
            len_reg       <= '0;
            dec_reg       <= '0;
            raw_sum_reg   <= '0;
            dec_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (line_done)
            begin
                phase_reg   <= slec_pkg::PH_OPEN;
                err_reg     <= slec_pkg::ST_OK;
                len_reg     <= '0;
                dec_reg     <= '0;
                raw_sum_reg <= raw_sum_next;
                dec_sum_reg <= dec_sum_next;
            end
            else if (item_pop)
            begin
                phase_reg <= phase_next;
                err_reg   <= err_next;
                len_reg   <= len_next;
                dec_reg   <= dec_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_done)
        begin
            code_count_reg   <= len_next;
            memory_count_reg <= mem_cnt;
            status_reg       <= err_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign code_count   = code_count_reg;
    assign memory_count = memory_count_reg;
    assign status       = status_reg;
    assign code_total   = raw_sum_reg;
    assign memory_total = dec_sum_reg;

    a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != slec_pkg::ST_OK) |-> memory_count_reg == '0)
        else $error("decoded count on a failed line");

    a_decoded_le_raw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> memory_count_reg <= code_count_reg)
        else $error("decoded count above raw length");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        line_done |=> (phase_reg == slec_pkg::PH_OPEN) && (len_reg == '0))
        else $error("line state not cleared after last byte");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !line_done)
        else $error("result register overwritten while stalled");

endmodule
`default_nettype wire
